>>> design/prc_pkg.sv
// Package with shared types and constants of the perspective remap coordinate block.
`default_nettype none
package prc_pkg;
  localparam int unsigned CoefW  = 48;
  localparam int unsigned NumCoef = 8;
  // Sums: 48-bit coefficient times up to 16-bit coordinate, three terms.
  localparam int unsigned SumW   = 66;
  // Dividend magnitude shifted left by 16 plus half the divisor.
  localparam int unsigned DvdW   = 84;
  localparam int unsigned ModW   = 66;
  localparam int unsigned QuoW   = DvdW;

  typedef enum logic [2:0] {
    RegCoefXx = 3'd0, RegCoefXy = 3'd1, RegCoefXo = 3'd2, RegCoefYx = 3'd3,
    RegCoefYy = 3'd4, RegCoefYo = 3'd5, RegCoefWx = 3'd6, RegCoefWy = 3'd7
  } reg_idx_e;

  localparam logic [CoefW-1:0] OneQ32 = 48'h0001_0000_0000;

  // Data carried along the divider chain, one copy per cell.
  typedef struct packed {
    logic [DvdW-1:0] dvd_x;
    logic [ModW-1:0] rem_x;
    logic [DvdW-1:0] dvd_y;
    logic [ModW-1:0] rem_y;
    logic [ModW-1:0] den;
    logic            neg_x;
    logic            neg_y;
    logic            degen;
  } div_lane_t;
endpackage
`default_nettype wire

>>> design/prc_stream_if.sv
// Valid/ready stream interfaces for coordinates and results.
`default_nettype none
interface prc_coord_if #(parameter int unsigned COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] dest_x;
  logic [COORD_BITS-1:0] dest_y;
  modport source (output valid, dest_x, dest_y, input ready);
  modport sink (input valid, dest_x, dest_y, output ready);
endinterface

interface prc_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] src_x;
  logic signed [31:0] src_y;
  logic               degenerate;
  logic               saturated;
  modport source (output valid, src_x, src_y, degenerate, saturated, input ready);
  modport sink (input valid, src_x, src_y, degenerate, saturated, output ready);
endinterface
`default_nettype wire

>>> design/perspective_remap_coordinate.sv
// Top level of the perspective remap coordinate generator.
// Usage:
// A destination pixel coordinate enters on the coordinate channel (valid/ready);
// its result appears on the result channel with the source
// coordinate in signed Q16.16, a degenerate flag for a zero denominator and a
// saturated flag when either coordinate was clipped.
// Eight Q16.32 coefficients are written over the APB-style port at 8*i.
// The pipeline is 3 front stages plus 84 divider cells plus one output stage.
// Throughput is one coordinate per cycle unless stalled: the restoring divider
// is laid out as a row of 84 cells, each producing one quotient bit per cycle
// for both coordinates and passing its partial remainder to the next cell.
// When the receiver stalls, the whole chain holds (a global enable), and the
// input is not ready only while the output register holds a result that has
// not been taken. Reset clears all valid bits and loads identity coefficients.
`default_nettype none
module perspective_remap_coordinate #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  prc_coord_if.sink        coord_i,
  prc_result_if.source     result_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import prc_pkg::*;

  logic [NumCoef-1:0][CoefW-1:0] coef_q;
  logic [2:0] ridx;
  assign ridx = paddr[5:3];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCoef; i++) begin
        coef_q[i] <= (i == int'(RegCoefXx) || i == int'(RegCoefYy)) ? OneQ32 : '0;
      end
    end else if (psel && penable && pwrite) begin
      coef_q[ridx] <= pwdata[CoefW-1:0];
    end
  end

  always_comb begin
    prdata = {{(64-CoefW){coef_q[ridx][CoefW-1]}}, coef_q[ridx]};
  end

  // The chain advances whenever the output register is free or being taken.
  logic out_v_q, en;
  assign en = !out_v_q || result_o.ready;
  assign coord_i.ready = en;

  logic       fv;
  div_lane_t  fl;
  prc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(coord_i.valid),
    .x_i(COORD_BITS'(coord_i.dest_x)), .y_i(COORD_BITS'(coord_i.dest_y)),
    .coef_i(coef_q), .valid_o(fv), .lane_o(fl)
  );

  logic      cv [QuoW+1];
  div_lane_t cl [QuoW+1];
  assign cv[0] = fv;
  assign cl[0] = fl;

  for (genvar g = 0; g < QuoW; g++) begin : g_cell
    prc_div_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .valid_i(cv[g]), .lane_i(cl[g]),
      .valid_o(cv[g+1]), .lane_o(cl[g+1])
    );
  end

  // Final saturation and sign restore.
  div_lane_t last;
  logic [QuoW-1:0] qx, qy;
  logic [31:0] sx_d, sy_d;
  logic satx, saty;
  assign last = cl[QuoW];
  assign qx = last.dvd_x;
  assign qy = last.dvd_y;

  always_comb begin
    satx = 1'b0;
    saty = 1'b0;
    if (!last.neg_x) begin
      if (qx > QuoW'(32'h7FFF_FFFF)) begin satx = 1'b1; sx_d = 32'h7FFF_FFFF; end
      else sx_d = qx[31:0];
    end else begin
      if (qx > QuoW'(32'h8000_0000)) begin satx = 1'b1; sx_d = 32'h8000_0000; end
      else sx_d = 32'(-qx[31:0]);
    end
    if (!last.neg_y) begin
      if (qy > QuoW'(32'h7FFF_FFFF)) begin saty = 1'b1; sy_d = 32'h7FFF_FFFF; end
      else sy_d = qy[31:0];
    end else begin
      if (qy > QuoW'(32'h8000_0000)) begin saty = 1'b1; sy_d = 32'h8000_0000; end
      else sy_d = 32'(-qy[31:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= cv[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      result_o.src_x      <= last.degen ? '0 : sx_d;
      result_o.src_y      <= last.degen ? '0 : sy_d;
      result_o.degenerate <= last.degen;
      result_o.saturated  <= !last.degen && (satx || saty);
    end
  end

  assign result_o.valid = out_v_q;
endmodule
`default_nettype wire

>>> design/prc_div_cell.sv
// One restoring division cell: produces one quotient bit for both coordinates.
`default_nettype none
module prc_div_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire prc_pkg::div_lane_t  lane_i,
  output logic                     valid_o,
  output prc_pkg::div_lane_t       lane_o
);
  import prc_pkg::*;

  div_lane_t lane_d;
  logic [ModW:0] tx, ty;

  always_comb begin
    lane_d = lane_i;
    tx = {lane_i.rem_x, lane_i.dvd_x[DvdW-1]};
    ty = {lane_i.rem_y, lane_i.dvd_y[DvdW-1]};
    lane_d.dvd_x = {lane_i.dvd_x[DvdW-2:0], 1'b0};
    lane_d.dvd_y = {lane_i.dvd_y[DvdW-2:0], 1'b0};
    if (tx >= {1'b0, lane_i.den}) begin
      tx = tx - {1'b0, lane_i.den};
      lane_d.dvd_x[0] = 1'b1;
    end
    if (ty >= {1'b0, lane_i.den}) begin
      ty = ty - {1'b0, lane_i.den};
      lane_d.dvd_y[0] = 1'b1;
    end
    lane_d.rem_x = tx[ModW-1:0];
    lane_d.rem_y = ty[ModW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_o <= lane_d;
    end
  end
endmodule
`default_nettype wire

>>> design/prc_front.sv
// Front stages: coefficient products, sums, sign handling and divider setup.
`default_nettype none
module prc_front #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic [COORD_BITS-1:0]      x_i,
  input  wire logic [COORD_BITS-1:0]      y_i,
  input  wire logic [prc_pkg::NumCoef-1:0][prc_pkg::CoefW-1:0] coef_i,
  output logic                            valid_o,
  output prc_pkg::div_lane_t              lane_o
);
  import prc_pkg::*;

  localparam int unsigned ProdW = CoefW + COORD_BITS + 1;

  // Stage 1: six products, each a coefficient times an unsigned coordinate, and the two offsets.
  // Stage 2: the three sums.
  logic signed [ProdW-1:0] p_q [6];
  logic signed [CoefW-1:0] off_x_q, off_y_q;
  logic v1_q, v2_q;
  logic signed [SumW-1:0] nx_q, ny_q, w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= $signed(coef_i[RegCoefXx]) * $signed({1'b0, x_i});
      p_q[1] <= $signed(coef_i[RegCoefXy]) * $signed({1'b0, y_i});
      p_q[2] <= $signed(coef_i[RegCoefYx]) * $signed({1'b0, x_i});
      p_q[3] <= $signed(coef_i[RegCoefYy]) * $signed({1'b0, y_i});
      p_q[4] <= $signed(coef_i[RegCoefWx]) * $signed({1'b0, x_i});
      p_q[5] <= $signed(coef_i[RegCoefWy]) * $signed({1'b0, y_i});
      off_x_q <= $signed(coef_i[RegCoefXo]);
      off_y_q <= $signed(coef_i[RegCoefYo]);
      nx_q <= SumW'(p_q[0]) + SumW'(p_q[1]) + SumW'(off_x_q);
      ny_q <= SumW'(p_q[2]) + SumW'(p_q[3]) + SumW'(off_y_q);
      w_q  <= SumW'(p_q[4]) + SumW'(p_q[5]) + SumW'($signed({1'b0, OneQ32}));
    end
  end

  // Stage 3: magnitudes, rounding offset and divider lane.
  logic [SumW-1:0] ax, ay, aw;
  always_comb begin
    ax = nx_q[SumW-1] ? SumW'(-nx_q) : nx_q;
    ay = ny_q[SumW-1] ? SumW'(-ny_q) : ny_q;
    aw = w_q[SumW-1]  ? SumW'(-w_q)  : w_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_o.dvd_x <= {2'b00, ax, 16'h0} + DvdW'(aw >> 1);
      lane_o.dvd_y <= {2'b00, ay, 16'h0} + DvdW'(aw >> 1);
      lane_o.rem_x <= '0;
      lane_o.rem_y <= '0;
      lane_o.den   <= aw;
      lane_o.neg_x <= nx_q[SumW-1] ^ w_q[SumW-1];
      lane_o.neg_y <= ny_q[SumW-1] ^ w_q[SumW-1];
      lane_o.degen <= (w_q == '0);
    end
  end
endmodule
`default_nettype wire

>>> design/prc_checker.sv
// Port-level checker for the perspective remap coordinate block, with its bind.
`default_nettype none
module prc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic degenerate,
  input wire logic saturated,
  input wire logic [31:0] src_x
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid || out_ready) |-> in_ready) else $error("ready low with free output");
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && degenerate |-> !saturated && src_x == 32'h0)
    else $error("degenerate result not zero");
endmodule

bind perspective_remap_coordinate prc_checker u_prc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_ready(coord_i.ready),
  .out_valid(result_o.valid), .out_ready(result_o.ready),
  .degenerate(result_o.degenerate), .saturated(result_o.saturated),
  .src_x(result_o.src_x)
);
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the perspective remap coordinate generator.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import prc_pkg::*;

  localparam int unsigned CoordBits = 12;
  // Pipeline depth given at the head of the block, with some margin.
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [CoordBits-1:0] dest_x;
    logic [CoordBits-1:0] dest_y;
  } coord_t;

  typedef struct packed {
    logic [31:0] src_x;
    logic [31:0] src_y;
    logic        degenerate;
    logic        saturated;
  } source_pt_t;

  typedef enum int {
    SetIdentity, SetAllMax, SetAllMin, SetAffine, SetProjective, SetVanishing, SetWild
  } coef_set_e;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [5:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  prc_coord_if #(.COORD_BITS(CoordBits)) coord_if ();
  prc_result_if result_if ();

  perspective_remap_coordinate #(.COORD_BITS(CoordBits)) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coord_i (coord_if),
    .result_o(result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // The testbench's own copy of the eight coefficients, in Q16.32.
  logic signed [CoefW-1:0] matrix_q[NumCoef];

  coord_t     coord_backlog[$];
  source_pt_t source_expected[$];

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned degenerate_seen;
  int unsigned saturated_seen;
  int unsigned coef_sets_loaded;
  logic        coord_taken;

  // The clock runs from time zero; reset is held low at the start and then released.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic signed [127:0] widen(input logic signed [CoefW-1:0] v);
    return v;
  endfunction

  // Rounds num/den to Q16.16, ties away from zero, then clips to 32 bits.
  function automatic logic [31:0] to_q16(input logic signed [127:0] num,
                                         input logic signed [127:0] den,
                                         inout logic clipped);
    logic          flip;
    logic [127:0]  mag_n;
    logic [127:0]  mag_d;
    logic [127:0]  quot;
    flip  = num[127] ^ den[127];
    mag_n = num[127] ? -num : num;
    mag_d = den[127] ? -den : den;
    quot  = ((mag_n << 16) + (mag_d >> 1)) / mag_d;
    if (!flip) begin
      if (quot > 128'h7FFF_FFFF) begin
        clipped = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return quot[31:0];
    end
    if (quot > 128'h8000_0000) begin
      clipped = 1'b1;
      return 32'h8000_0000;
    end
    return 32'd0 - quot[31:0];
  endfunction

  // Maps one destination pixel through the loaded inverse homography.
  function automatic source_pt_t warp_point(input coord_t c);
    source_pt_t           p;
    logic signed [127:0]  x;
    logic signed [127:0]  y;
    logic signed [127:0]  nx;
    logic signed [127:0]  ny;
    logic signed [127:0]  w;
    logic                 clipped;
    x  = $signed({116'd0, c.dest_x});
    y  = $signed({116'd0, c.dest_y});
    nx = widen(matrix_q[RegCoefXx]) * x + widen(matrix_q[RegCoefXy]) * y
         + widen(matrix_q[RegCoefXo]);
    ny = widen(matrix_q[RegCoefYx]) * x + widen(matrix_q[RegCoefYy]) * y
         + widen(matrix_q[RegCoefYo]);
    w  = widen(matrix_q[RegCoefWx]) * x + widen(matrix_q[RegCoefWy]) * y
         + (128'sd1 <<< 32);
    p = '0;
    if (w == 0) begin
      p.degenerate = 1'b1;
      return p;
    end
    clipped = 1'b0;
    p.src_x = to_q16(nx, w, clipped);
    p.src_y = to_q16(ny, w, clipped);
    p.saturated = clipped;
    return p;
  endfunction

  // Sender: a new coordinate is offered only once the previous one has been
  // taken, so valid never drops while an item is still waiting.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!coord_if.valid || coord_taken) begin
        if (coord_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          {coord_if.dest_x, coord_if.dest_y} <= coord_backlog.pop_front();
          coord_if.valid <= 1'b1;
        end else begin
          coord_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the receiver, counted here on its own.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left   <= HoldOffCycles;
    end
  end

  // Receiver: random stalls, and ready held low throughout a hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      result_if.ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Monitor: every accepted coordinate gets a prediction, every accepted
  // result is checked against the oldest one.
  always @(posedge clk_i) begin
    source_pt_t got;
    source_pt_t want;
    coord_taken <= coord_if.valid && coord_if.ready;
    if (rst_ni && coord_if.valid && coord_if.ready) begin
      source_expected = {source_expected,
                         warp_point({coord_if.dest_x, coord_if.dest_y})};
    end
    if (rst_ni && result_if.valid && result_if.ready) begin
      got = {result_if.src_x, result_if.src_y, result_if.degenerate, result_if.saturated};
      results_checked <= results_checked + 1;
      if (got.degenerate) degenerate_seen <= degenerate_seen + 1;
      if (got.saturated) saturated_seen <= saturated_seen + 1;
      if (source_expected.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < MaxReports) begin
          $display("result transfer with nothing expected: %p", got);
        end
      end else begin
        want = source_expected.pop_front();
        if (got !== want) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < MaxReports) begin
            $display("mismatch: expected x=%h y=%h dg=%b sat=%b, got x=%h y=%h dg=%b sat=%b",
                     want.src_x, want.src_y, want.degenerate, want.saturated,
                     got.src_x, got.src_y, got.degenerate, got.saturated);
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL perspective_remap_coordinate");
      $finish;
    end
  end

  // One register write: a setup phase, then the access phase in which the
  // register takes the value.
  task automatic write_coef(input reg_idx_e idx, input logic signed [CoefW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 6'(int'(idx) * 8);
    pwdata  <= 64'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    matrix_q[idx] = value;
  endtask

  task automatic load_matrix(input logic signed [CoefW-1:0] m[NumCoef]);
    for (int i = 0; i < NumCoef; i++) write_coef(reg_idx_e'(i), m[i]);
    coef_sets_loaded++;
  endtask

  // Waits until every offered coordinate has produced its result, then lets
  // the pipeline settle before registers may change.
  task automatic drain();
    while (coord_backlog.size() != 0 || coord_if.valid || source_expected.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic signed [CoefW-1:0] rand_coef(input int unsigned span_bits);
    logic [63:0] r;
    r = {$urandom, $urandom};
    r = r & ((64'd1 << span_bits) - 1);
    if ($urandom_range(1)) return -$signed(r[CoefW-1:0]);
    return $signed(r[CoefW-1:0]);
  endfunction

  task automatic pick_matrix(input coef_set_e kind, output logic signed [CoefW-1:0] m[NumCoef]);
    int unsigned k;
    for (int i = 0; i < NumCoef; i++) m[i] = '0;
    case (kind)
      SetIdentity: begin
        m[RegCoefXx] = OneQ32;
        m[RegCoefYy] = OneQ32;
      end
      SetAllMax: begin
        for (int i = 0; i < NumCoef; i++) m[i] = {1'b0, {(CoefW-1){1'b1}}};
      end
      SetAllMin: begin
        for (int i = 0; i < NumCoef; i++) m[i] = {1'b1, {(CoefW-1){1'b0}}};
      end
      SetAffine: begin
        for (int i = 0; i < 6; i++) m[i] = rand_coef($urandom_range(20, 34));
        m[RegCoefXo] = rand_coef($urandom_range(30, 44));
        m[RegCoefYo] = rand_coef($urandom_range(30, 44));
      end
      SetProjective: begin
        for (int i = 0; i < 6; i++) m[i] = rand_coef($urandom_range(24, 34));
        m[RegCoefWx] = rand_coef($urandom_range(12, 22));
        m[RegCoefWy] = rand_coef($urandom_range(12, 22));
      end
      SetVanishing: begin
        // The denominator reaches zero along the column 2^k.
        k = $urandom_range(0, 3);
        for (int i = 0; i < 6; i++) m[i] = rand_coef($urandom_range(24, 36));
        m[RegCoefWx] = -$signed(CoefW'(OneQ32 >> k));
      end
      default: begin
        for (int i = 0; i < NumCoef; i++) m[i] = rand_coef(CoefW);
      end
    endcase
  endtask

  task automatic queue_point(input int unsigned x, input int unsigned y);
    coord_t c;
    c.dest_x = x[CoordBits-1:0];
    c.dest_y = y[CoordBits-1:0];
    coord_backlog = {coord_backlog, c};
  endtask

  task automatic queue_random(input int unsigned count, input logic near_origin);
    for (int i = 0; i < count; i++) begin
      if (near_origin && $urandom_range(1)) queue_point($urandom_range(0, 15), $urandom);
      else queue_point($urandom, $urandom);
    end
  endtask

  task automatic queue_corners();
    queue_point(0, 0);
    queue_point(4095, 4095);
    queue_point(4095, 0);
    queue_point(0, 4095);
    queue_point(2048, 2048);
  endtask

  initial begin
    logic signed [CoefW-1:0] m[NumCoef];
    coef_set_e kind;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    coord_if.valid = 1'b0;
    coord_if.dest_x = '0;
    coord_if.dest_y = '0;
    result_if.ready = 1'b0;
    coord_taken = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    cycle_count = 0;
    mismatch_count = 0;
    results_checked = 0;
    degenerate_seen = 0;
    saturated_seen = 0;
    coef_sets_loaded = 0;
    pick_matrix(SetIdentity, matrix_q);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Reset coefficients first, so the identity map is checked
    // before any register write.
    queue_corners();
    drain();
    // Extreme coefficients: every register at its largest, then at its smallest value.
    pick_matrix(SetAllMax, m);
    load_matrix(m);
    queue_corners();
    queue_point(1, 1);
    drain();
    pick_matrix(SetAllMin, m);
    load_matrix(m);
    queue_corners();
    queue_point(1, 1);
    drain();
    // Half-way values: a coefficient of 2^-17 makes exact ties at odd
    // coordinates, which must round away from zero in both signs.
    pick_matrix(SetIdentity, m);
    m[RegCoefXx] = 48'sd32768;
    m[RegCoefYy] = -48'sd32768;
    load_matrix(m);
    queue_point(1, 1);
    queue_point(3, 3);
    queue_point(2, 4095);
    drain();
    // A zero denominator on column one flags the point as degenerate.
    pick_matrix(SetIdentity, m);
    m[RegCoefWx] = -$signed(OneQ32);
    m[RegCoefXo] = 48'sh7FFF_0000_0000;
    load_matrix(m);
    queue_point(1, 0);
    queue_point(1, 4095);
    queue_point(0, 7);
    queue_point(2, 9);
    drain();

    // Random part: twelve phases of 68 coordinates (150 in phase 4), walking
    // through the idling patterns and the coefficient families.
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
        default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
      endcase
      kind = coef_set_e'(phase % 7);
      pick_matrix(kind, m);
      load_matrix(m);
      if (phase == 4) begin
        // The receiver holds off for a long stretch while coordinates keep
        // coming, so the chain fills and back-pressure reaches the input.
        hold_requests = hold_requests + 1;
        queue_random(150, 1'b0);
      end else begin
        queue_random(68, kind == SetVanishing);
      end
      drain();
    end

    $display("Checked %0d results over %0d coefficient sets; %0d degenerate, %0d clipped.",
             results_checked, coef_sets_loaded + 1, degenerate_seen, saturated_seen);
    $display("Idle and stall patterns and one long receiver hold-off were exercised.");
    if (mismatch_count == 0 && source_expected.size() == 0) begin
      $display("PASS perspective_remap_coordinate");
    end else begin
      $display("FAIL perspective_remap_coordinate");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
design/prc_pkg.sv
design/prc_stream_if.sv
design/prc_div_cell.sv
design/prc_front.sv
design/perspective_remap_coordinate.sv
design/prc_checker.sv
tb/sv/testbench.sv
